// ----- sv/byte_stuffed_frame_transmitter_core_assert.svh -----
// Assertion macros used by the frame transmitter back end
`ifndef BYTE_STUFFED_FRAME_TRANSMITTER_CORE_ASSERT_SVH
`define BYTE_STUFFED_FRAME_TRANSMITTER_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset
`define BSFT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define BSFT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- sv/bsft_pkg.sv -----
// Shared types, constants and helpers of the byte-stuffed frame transmitter
package bsft_pkg;

   localparam logic [7:0] FLAG_BYTE    = 8'h7E;
   localparam logic [7:0] ESC_BYTE     = 8'h7D;
   localparam logic [7:0] ESC_FLAG     = 8'h5E;
   localparam logic [7:0] ESC_ESC      = 8'h5D;
   localparam logic [7:0] CTRL_ONE     = 8'h40;
   localparam logic [7:0] CTRL_ZERO    = 8'h00;
   localparam logic [7:0] ADDRESS_INIT = 8'h03;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Output slots of one command, in transmit order
   localparam int SLOT_COUNT = 9;
   localparam int SLOT_W     = 4;
   localparam logic [SLOT_W-1:0] SLOT_FLAG  = 4'd0;
   localparam logic [SLOT_W-1:0] SLOT_ADDR  = 4'd1;
   localparam logic [SLOT_W-1:0] SLOT_CTRL  = 4'd2;
   localparam logic [SLOT_W-1:0] SLOT_HCHK  = 4'd3;
   localparam logic [SLOT_W-1:0] SLOT_DATA0 = 4'd4;
   localparam logic [SLOT_W-1:0] SLOT_DATA1 = 4'd5;
   localparam logic [SLOT_W-1:0] SLOT_CHK0  = 4'd6;
   localparam logic [SLOT_W-1:0] SLOT_CHK1  = 4'd7;
   localparam logic [SLOT_W-1:0] SLOT_CLOSE = 4'd8;

   typedef logic [SLOT_COUNT-1:0] slot_mask_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       frame_end;
   } rsp_type;

   // One classified item, as handed from front to back
   typedef struct packed {
      logic [7:0]    addr;
      logic [7:0]    ctrl;
      logic [7:0]    data;
      logic [7:0]    check;
      slot_mask_type mask;
   } cmd_type;

   function automatic logic needs_escape(input logic [7:0] b);
      return (b == FLAG_BYTE) || (b == ESC_BYTE);
   endfunction

   // First byte on the line for a payload or check byte
   function automatic logic [7:0] stuff_first(input logic [7:0] b);
      return needs_escape(b) ? ESC_BYTE : b;
   endfunction

   // Second byte on the line for an escaped byte
   function automatic logic [7:0] stuff_second(input logic [7:0] b);
      return (b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
   endfunction

endpackage

// ----- sv/bsft_front.sv -----
// Front end: accepts payload bytes, tracks frame state and builds commands
module bsft_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  bsft_pkg::req_type req_item,
   input  logic              csr_write_en,
   input  logic [7:0]        csr_wdata,
   input  logic              q_full,
   output logic              q_push,
   output bsft_pkg::cmd_type q_cmd
);

   logic       in_frame_ff, in_frame_in;
   logic       seq_ff, seq_in;
   logic [7:0] check_ff, check_in;
   logic [7:0] addr_ff, addr_in;

   logic       opening;
   logic [7:0] new_check;

   assign q_push    = req_push && !q_full;
   assign opening   = !in_frame_ff;
   assign new_check = (opening ? 8'h00 : check_ff) ^ req_item.data_byte;

   // Classify the item into a command
   always_comb begin
      q_cmd.addr  = addr_ff;
      q_cmd.ctrl  = seq_ff ? bsft_pkg::CTRL_ONE : bsft_pkg::CTRL_ZERO;
      q_cmd.data  = req_item.data_byte;
      q_cmd.check = new_check;
      q_cmd.mask  = '0;
      q_cmd.mask[bsft_pkg::SLOT_FLAG]  = opening;
      q_cmd.mask[bsft_pkg::SLOT_ADDR]  = opening;
      q_cmd.mask[bsft_pkg::SLOT_CTRL]  = opening;
      q_cmd.mask[bsft_pkg::SLOT_HCHK]  = opening;
      q_cmd.mask[bsft_pkg::SLOT_DATA0] = 1'b1;
      q_cmd.mask[bsft_pkg::SLOT_DATA1] = bsft_pkg::needs_escape(req_item.data_byte);
      q_cmd.mask[bsft_pkg::SLOT_CHK0]  = req_item.last_byte;
      q_cmd.mask[bsft_pkg::SLOT_CHK1]  = req_item.last_byte
                                         && bsft_pkg::needs_escape(new_check);
      q_cmd.mask[bsft_pkg::SLOT_CLOSE] = req_item.last_byte;
   end

   // Advance frame state on each transfer and take the address from CSR writes
   always_comb begin
      in_frame_in = in_frame_ff;
      seq_in      = seq_ff;
      check_in    = check_ff;
      addr_in     = csr_write_en ? csr_wdata : addr_ff;
      if (q_push) begin
         if (opening) begin
            seq_in = !seq_ff;
         end
         if (req_item.last_byte) begin
            in_frame_in = 1'b0;
            check_in    = 8'h00;
         end else begin
            in_frame_in = 1'b1;
            check_in    = new_check;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         seq_ff      <= 1'b0;
         check_ff    <= 8'h00;
         addr_ff     <= bsft_pkg::ADDRESS_INIT;
      end else begin
         in_frame_ff <= in_frame_in;
         seq_ff      <= seq_in;
         check_ff    <= check_in;
         addr_ff     <= addr_in;
      end
   end

endmodule

// ----- sv/bsft_queue.sv -----
// Short command queue between front end and back end
module bsft_queue #(
   parameter int DEPTH = bsft_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bsft_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output bsft_pkg::cmd_type head_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bsft_pkg::cmd_type slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = slots_ff[rd_ptr_ff];

   // Advance pointers with explicit wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- sv/bsft_back.sv -----
// Back end: walks the slots of each command and drives the line bytes
`include "byte_stuffed_frame_transmitter_core_assert.svh"

module bsft_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  bsft_pkg::cmd_type q_head,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output bsft_pkg::rsp_type rsp_item
);

   bsft_pkg::cmd_type       cmd_ff, cmd_in;
   bsft_pkg::slot_mask_type mask_ff, mask_in;
   bsft_pkg::rsp_type       out_ff, out_in;
   logic                    out_valid_ff, out_valid_in;

   logic                         can_emit, emit;
   logic [bsft_pkg::SLOT_W-1:0]  slot;
   bsft_pkg::slot_mask_type      rest;
   bsft_pkg::rsp_type            slot_rsp;

   assign can_emit  = !out_valid_ff || rsp_pop;
   assign emit      = (mask_ff != '0) && can_emit;
   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;

   // Pick the earliest pending slot
   always_comb begin
      slot = bsft_pkg::SLOT_CLOSE;
      for (int i = bsft_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            slot = bsft_pkg::SLOT_W'(i);
         end
      end
   end

   // Form the byte for the chosen slot
   always_comb begin
      slot_rsp.frame_end = 1'b0;
      case (slot)
         bsft_pkg::SLOT_FLAG:  slot_rsp.line_byte = bsft_pkg::FLAG_BYTE;
         bsft_pkg::SLOT_ADDR:  slot_rsp.line_byte = cmd_ff.addr;
         bsft_pkg::SLOT_CTRL:  slot_rsp.line_byte = cmd_ff.ctrl;
         bsft_pkg::SLOT_HCHK:  slot_rsp.line_byte = cmd_ff.addr ^ cmd_ff.ctrl;
         bsft_pkg::SLOT_DATA0: slot_rsp.line_byte = bsft_pkg::stuff_first(cmd_ff.data);
         bsft_pkg::SLOT_DATA1: slot_rsp.line_byte = bsft_pkg::stuff_second(cmd_ff.data);
         bsft_pkg::SLOT_CHK0:  slot_rsp.line_byte = bsft_pkg::stuff_first(cmd_ff.check);
         bsft_pkg::SLOT_CHK1:  slot_rsp.line_byte = bsft_pkg::stuff_second(cmd_ff.check);
         bsft_pkg::SLOT_CLOSE: begin
            slot_rsp.line_byte = bsft_pkg::FLAG_BYTE;
            slot_rsp.frame_end = 1'b1;
         end
         default:              slot_rsp.line_byte = bsft_pkg::FLAG_BYTE;
      endcase
   end

   // Drop the emitted slot and load the next command once the current one drains
   always_comb begin
      rest   = emit ? (mask_ff & ~(bsft_pkg::slot_mask_type'(1) << slot)) : mask_ff;
      q_pop  = (rest == '0) && !q_empty;
      cmd_in = q_pop ? q_head : cmd_ff;
      mask_in = q_pop ? q_head.mask : rest;
   end

   // Hold the output byte until it is transferred
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_in       = slot_rsp;
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      out_ff <= out_in;
   end

   `BSFT_ASSERT(a_pending_reaches_output, (mask_ff != '0 && !out_valid_ff) |=> out_valid_ff, "pending slot did not reach the output register")
   `BSFT_ASSERT(a_close_is_flag, (out_valid_ff && out_ff.frame_end) |-> (out_ff.line_byte == bsft_pkg::FLAG_BYTE), "frame end marked on a byte other than the flag")
   `BSFT_ASSERT_ALWAYS(a_no_load_while_busy, q_pop |-> (rest == '0), "command loaded while slots remain")

endmodule

// ----- sv/byte_stuffed_frame_transmitter_core.sv -----
// Top level of the byte-stuffed frame transmitter
//
// Takes payload bytes with a last-byte marker and sends framed, byte-stuffed
// line bytes: flag, address, alternating control byte and header check open
// each frame, payload bytes and the closing XOR check are escaped, and a
// closing flag (marked by frame_end) ends it. The front end takes one payload
// byte per cycle while its command queue (QUEUE_DEPTH entries) has room; the
// back end sends one line byte per cycle while the receiver keeps popping, so
// an item yields 1 to 9 line bytes (1 for a plain byte, 2 if escaped, plus 4
// for a frame header and 2 to 3 for the check and closing flag). The single
// line byte per cycle of the back-end sequencer sets the sustained rate. With
// the back end idle, the first line byte of an item passes through the queue,
// the back-end command register and the output register to the result side.
// csr_wdata sets the address byte for frame headers opened after the write.
module byte_stuffed_frame_transmitter_core #(
   parameter int QUEUE_DEPTH = bsft_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  bsft_pkg::req_type req_item,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output bsft_pkg::rsp_type rsp_item,
   input  logic              csr_write_en,
   input  logic [7:0]        csr_wdata
);

   logic              q_push, q_pop, q_full, q_empty;
   bsft_pkg::cmd_type q_cmd, q_head;

   assign req_full = q_full;

   // Accept and classify payload bytes
   bsft_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_item     (req_item),
      .csr_write_en (csr_write_en),
      .csr_wdata    (csr_wdata),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_cmd        (q_cmd)
   );

   // Decouple the two sides
   bsft_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head_cmd (q_head)
   );

   // Send line bytes
   bsft_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule
